// ===== rtl/mpbd_pkg.sv =====
// Shared types and constants for the mipmap box downsampler.
package mpbd_pkg;

	localparam int MaxWidth   = 1024;
	localparam int MaxLevels  = 10;
	localparam int Channels   = 4;
	localparam int SampleBits = 16;
	localparam int LvlBits    = 4;
	localparam int CoordBits  = 10;
	localparam int DimBits    = 11;
	localparam int SumBits    = SampleBits + 1;
	localparam int PairDepth  = MaxWidth * Channels;
	localparam int PairAddrBits = $clog2(PairDepth);
	localparam int LeftDepth  = MaxLevels * Channels;
	localparam int LeftAddrBits = $clog2(LeftDepth);

	localparam logic [1:0] RegWidth    = 2'd0;
	localparam logic [1:0] RegHeight   = 2'd1;
	localparam logic [1:0] RegLevels   = 2'd2;
	localparam logic [1:0] RegChannels = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT,
		ST_WAIT
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;     // take input beat
		logic rd;       // fetch stores for current level
		logic step;     // emit done: advance counters, update stores
		logic clr_pos;  // restart all level counters
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic last;     // current level is the final one for this beat
	} stat_t;

	// Offset of a level's pairs within the pair-sum store.
	function automatic logic [PairAddrBits-1:0] pair_base(input logic [LvlBits-1:0] l);
		logic [PairAddrBits-1:0] off;
		off = '0;
		for (int k = 0; k < MaxLevels; k++)
			if (k < int'(l))
				off = off + PairAddrBits'(MaxWidth >> (k + 1));
		return off;
	endfunction

endpackage

// ===== rtl/mpbd_ram.sv =====
// Generic single-port-write, registered-read RAM.
module mpbd_ram #(
	parameter int Width = 16,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write, then register read data.
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/mpbd_ctrl.sv =====
// Controller FSM sequencing levels of one input beat.
module mpbd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  logic                cfg_we,
	output mpbd_pkg::cmd_t      cmd,
	input  mpbd_pkg::stat_t     stat
);
	mpbd_pkg::state_t state_q, state_d;
	logic out_go;

	assign out_go = out_valid && !out_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mpbd_pkg::ST_IDLE: if (in_valid) state_d = mpbd_pkg::ST_READ;
			mpbd_pkg::ST_READ: state_d = mpbd_pkg::ST_EMIT;
			mpbd_pkg::ST_EMIT: if (!out_stall) state_d = stat.last ? mpbd_pkg::ST_IDLE
					: mpbd_pkg::ST_READ;
			mpbd_pkg::ST_WAIT: state_d = mpbd_pkg::ST_IDLE;
			default: state_d = mpbd_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		cmd         = '0;
		cmd.clr_pos = cfg_we;
		case (state_q)
			mpbd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			mpbd_pkg::ST_READ: cmd.rd = 1'b1;
			mpbd_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				cmd.step  = !out_stall;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mpbd_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

`ifndef SYNTH
	a_no_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mpbd_pkg::ST_IDLE |-> !out_valid) else $error("out valid in idle");
	a_emit_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mpbd_pkg::ST_READ |=> state_q == mpbd_pkg::ST_EMIT)
		else $error("read not followed by emit");
	a_load_goes_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == mpbd_pkg::ST_READ) else $error("load lost");
	a_step_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> out_go) else $error("step without beat");
`endif
endmodule

// ===== rtl/mpbd_dpath.sv =====
// Datapath: config, level counters, stores and averaging.
module mpbd_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_idx,
	input  logic                               cfg_known,
	input  logic [mpbd_pkg::DimBits-1:0]       cfg_data,
	input  logic [mpbd_pkg::SampleBits-1:0]    pix [mpbd_pkg::Channels],
	input  mpbd_pkg::cmd_t                     cmd,
	output mpbd_pkg::stat_t                    stat,
	output logic [mpbd_pkg::LvlBits-1:0]       lvl,
	output logic [mpbd_pkg::CoordBits-1:0]     ox,
	output logic [mpbd_pkg::CoordBits-1:0]     oy,
	output logic [mpbd_pkg::SampleBits-1:0]    val [mpbd_pkg::Channels]
);
	localparam int CB = $clog2(mpbd_pkg::Channels);
	localparam int SB = mpbd_pkg::SampleBits;

	logic [mpbd_pkg::DimBits-1:0] width_q, height_q;
	logic [3:0] levels_q;
	logic [2:0] chans_q;
	logic [mpbd_pkg::CoordBits-1:0] col_q [mpbd_pkg::MaxLevels];
	logic [mpbd_pkg::CoordBits-1:0] row_q [mpbd_pkg::MaxLevels];
	logic [SB-1:0] left_q [mpbd_pkg::Channels][mpbd_pkg::MaxLevels];
	logic [SB-1:0] v_q [mpbd_pkg::Channels];
	logic [mpbd_pkg::LvlBits-1:0] lvl_q;
	logic [mpbd_pkg::DimBits-1:0] wc, hc, wl, hl;
	logic [mpbd_pkg::LvlBits-1:0] nlev;
	logic [2:0] nch;
	logic [mpbd_pkg::CoordBits-1:0] x, y;
	logic [mpbd_pkg::SumBits-1:0] above [mpbd_pkg::Channels];
	logic [mpbd_pkg::PairAddrBits-1:0] pbase;
	logic last;

	// Clamp configuration.
	always_comb begin
		wc = (width_q == '0) ? 11'd1 : (width_q > 11'(mpbd_pkg::MaxWidth))
			? 11'(mpbd_pkg::MaxWidth) : width_q;
		hc = (height_q == '0) ? 11'd1 : (height_q > 11'(mpbd_pkg::MaxWidth))
			? 11'(mpbd_pkg::MaxWidth) : height_q;
		nlev = (levels_q == '0) ? 4'd1 : (levels_q > 4'(mpbd_pkg::MaxLevels))
			? 4'(mpbd_pkg::MaxLevels) : levels_q;
		nch = (chans_q == '0) ? 3'd1 : (chans_q > 3'(mpbd_pkg::Channels))
			? 3'(mpbd_pkg::Channels) : chans_q;
		wl = wc >> lvl_q;
		hl = hc >> lvl_q;
		if (wl == '0) wl = 11'd1;
		if (hl == '0) hl = 11'd1;
	end

	assign x     = col_q[lvl_q];
	assign y     = row_q[lvl_q];
	assign last  = (lvl_q + 4'd1 >= nlev) || !x[0] || !y[0];
	assign stat.last = last;
	assign lvl   = lvl_q;
	assign ox    = x;
	assign oy    = y;
	assign val   = v_q;
	assign pbase = mpbd_pkg::pair_base(lvl_q) + mpbd_pkg::PairAddrBits'(x >> 1);

	// Pair-sum store, one bank per channel.
	for (genvar c = 0; c < mpbd_pkg::Channels; c++) begin : g_bank
		logic we;
		logic [mpbd_pkg::SumBits-1:0] wd;
		assign we = cmd.step && !(lvl_q + 4'd1 >= nlev) && x[0] && !y[0]
			&& (CB'(c) < CB'(nch) || nch > 3'(mpbd_pkg::Channels - 1));
		assign wd = {1'b0, left_q[c][lvl_q]} + {1'b0, v_q[c]};
		mpbd_ram #(.Width(mpbd_pkg::SumBits), .Depth(mpbd_pkg::MaxWidth)) u_ram (
			.clk(clk), .we(we), .waddr(pbase[$clog2(mpbd_pkg::MaxWidth)-1:0]),
			.wdata(wd), .raddr(pbase[$clog2(mpbd_pkg::MaxWidth)-1:0]),
			.rdata(above[c]));
	end

	// Config registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'(mpbd_pkg::MaxWidth);
			height_q <= 11'(mpbd_pkg::MaxWidth);
			levels_q <= 4'd1;
			chans_q  <= 3'd4;
		end else if (cfg_we && cfg_known) begin
			case (cfg_idx)
				mpbd_pkg::RegWidth:    width_q  <= cfg_data;
				mpbd_pkg::RegHeight:   height_q <= cfg_data;
				mpbd_pkg::RegLevels:   levels_q <= cfg_data[3:0];
				mpbd_pkg::RegChannels: chans_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Level counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < mpbd_pkg::MaxLevels; l++) begin
				col_q[l] <= '0;
				row_q[l] <= '0;
			end
		end else if (cmd.clr_pos) begin
			for (int l = 0; l < mpbd_pkg::MaxLevels; l++) begin
				col_q[l] <= '0;
				row_q[l] <= '0;
			end
		end else if (cmd.step) begin
			if (11'(x) + 11'd1 >= wl) begin
				col_q[lvl_q] <= '0;
				row_q[lvl_q] <= (11'(y) + 11'd1 >= hl) ? '0 : y + 10'd1;
			end else
				col_q[lvl_q] <= x + 10'd1;
		end
	end

	// Current level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lvl_q <= '0;
		else if (cmd.load)
			lvl_q <= '0;
		else if (cmd.step && !last)
			lvl_q <= lvl_q + 4'd1;
	end

	// Load, average, hold left pixels; inactive channels stay zero.
	always_ff @(posedge clk) begin
		for (int c = 0; c < mpbd_pkg::Channels; c++) begin
			if (cmd.load)
				v_q[c] <= (3'(c) < nch) ? pix[c] : '0;
			else if (cmd.step && !last && 3'(c) < nch)
				v_q[c] <= SB'((19'(above[c]) + 19'(left_q[c][lvl_q])
					+ 19'(v_q[c])) >> 2);
			if (cmd.step && !(lvl_q + 4'd1 >= nlev) && !x[0] && 3'(c) < nch)
				left_q[c][lvl_q] <= v_q[c];
		end
	end

`ifndef SYNTH
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> lvl_q < nlev) else $error("level past count");
	a_lvl_reset_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> lvl_q == '0) else $error("level not cleared");
	a_x_in_width: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> 11'(x) < wl || $past(cfg_we)) else $error("column out of range");
`endif
endmodule

// ===== rtl/mipmap_pyramid_box_downsampler.sv =====
// Top level of the mipmap pyramid box downsampler.
// Takes one base pixel per input beat and emits its level 0 echo plus every
// higher-level pixel it completes, lowest level first, with last_of_run on
// the final one. Each result takes a pair-sum RAM read, then the output beat
// (held under out_stall), as the per-level line store has a registered read.
// A new input is taken only when idle, after the previous one's final result.
// Configuration writes restart all level positions at zero.
module mipmap_pyramid_box_downsampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] pixel_c0,
	input  logic [15:0] pixel_c1,
	input  logic [15:0] pixel_c2,
	input  logic [15:0] pixel_c3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  level,
	output logic [9:0]  out_x,
	output logic [9:0]  out_y,
	output logic [15:0] avg_c0,
	output logic [15:0] avg_c1,
	output logic [15:0] avg_c2,
	output logic [15:0] avg_c3,
	output logic        last_of_run,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	mpbd_pkg::cmd_t  cmd;
	mpbd_pkg::stat_t stat;
	logic [15:0] pix [4];
	logic [15:0] val [4];

	assign pix = '{pixel_c0, pixel_c1, pixel_c2, pixel_c3};
	assign avg_c0 = val[0];
	assign avg_c1 = val[1];
	assign avg_c2 = val[2];
	assign avg_c3 = val[3];
	assign last_of_run = stat.last;

	mpbd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cfg_we(cfg_we),
		.cmd(cmd), .stat(stat));

	mpbd_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index),
		.cfg_known(1'b1), .cfg_data(cfg_data), .pix(pix), .cmd(cmd), .stat(stat),
		.lvl(level), .ox(out_x), .oy(out_y), .val(val));
endmodule
